// ----- design/pcfp_pkg.sv -----
// Shared constants, types and codes of the preamble checksum frame parser.
package pcfp_pkg;

  localparam int FRAME_LEN   = 16;
  localparam int FRAME_AW    = $clog2(FRAME_LEN);
  localparam int BYTE_W      = 8;
  localparam int INDEX_W     = 6;
  localparam int CFG_INDEX_W = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [INDEX_W-1:0] LAST_IDX = INDEX_W'(FRAME_LEN - 1);

  typedef enum logic [1:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_DATA,
    PH_SUM
  } phase_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FIRST_PREAMBLE  = 2'd0,
    REG_SECOND_PREAMBLE = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic [INDEX_W-1:0] idx;
    logic               commit;
  } entry_t;

endpackage

// ----- design/pcfp_if.sv -----
// Handshake channel interfaces of the preamble checksum frame parser.
interface pcfp_rx_if;
  logic                      valid;
  logic                      ready;
  logic [pcfp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface pcfp_frame_if;
  logic                         valid;
  logic                         ready;
  logic [pcfp_pkg::BYTE_W-1:0]  frame_byte;
  logic [pcfp_pkg::INDEX_W-1:0] byte_index;
  logic                         frame_last;

  modport source (output valid, output frame_byte, output byte_index, output frame_last,
                  input ready);
  modport sink (input valid, input frame_byte, input byte_index, input frame_last,
                output ready);
endinterface

interface pcfp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pcfp_pkg::CFG_INDEX_W-1:0] index;
  logic [pcfp_pkg::BYTE_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/preamble_checksum_frame_parser_top.sv -----
// Top level of the preamble checksum frame parser.
// The front end takes one received byte per cycle whenever its four-entry request
// queue has room, hunts for the two preamble bytes, keeps the running 8-bit sum
// and sends store and commit requests to the back end. The back end writes bytes
// into a FRAME_LEN-byte store and, after a frame whose checksum matched, reads
// it out at one byte per cycle while the output is ready, through a registered
// memory read; while it drains, the back end takes no requests and the front
// end keeps accepting bytes until the queue is full. Mismatched frames are
// dropped without output. The preamble values are written through the
// configuration channel, by the user only while the block is idle, which the
// block itself does not enforce, and reset to 0xAA and 0x55.
module preamble_checksum_frame_parser_top (
  input  logic          clk,
  input  logic          rst,
  pcfp_rx_if.sink       rx,
  pcfp_cfg_if.sink      cfg,
  pcfp_frame_if.source  frame
);

  logic              push;
  logic              full;
  logic              pop;
  logic              q_valid;
  pcfp_pkg::entry_t  push_entry;
  pcfp_pkg::entry_t  q_entry;

  pcfp_front u_front (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx),
    .cfg   (cfg),
    .full  (full),
    .push  (push),
    .entry (push_entry)
  );

  pcfp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .not_empty  (q_valid),
    .head       (q_entry)
  );

  pcfp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .pop     (pop),
    .frame   (frame)
  );

endmodule

// ----- design/pcfp_front.sv -----
// Front end: preamble hunt, byte classification and running checksum.
module pcfp_front (
  input  logic                 clk,
  input  logic                 rst,
  pcfp_rx_if.sink              rx,
  pcfp_cfg_if.sink             cfg,
  input  logic                 full,
  output logic                 push,
  output pcfp_pkg::entry_t     entry
);

  pcfp_pkg::phase_t                 phase;
  pcfp_pkg::phase_t                 phase_next;
  logic [pcfp_pkg::INDEX_W-1:0]     count;
  logic [pcfp_pkg::INDEX_W-1:0]     count_next;
  logic [pcfp_pkg::BYTE_W-1:0]      sum;
  logic [pcfp_pkg::BYTE_W-1:0]      sum_next;
  logic [pcfp_pkg::BYTE_W-1:0]      first_preamble;
  logic [pcfp_pkg::BYTE_W-1:0]      second_preamble;
  logic                             accept;

  assign rx.ready  = !full;
  assign cfg.ready = 1'b1;
  assign accept    = rx.valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_preamble  <= 8'd170;
      second_preamble <= 8'd85;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        pcfp_pkg::REG_FIRST_PREAMBLE:  first_preamble  <= cfg.data;
        pcfp_pkg::REG_SECOND_PREAMBLE: second_preamble <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= pcfp_pkg::PH_HUNT1;
      count <= '0;
      sum   <= '0;
    end else begin
      phase <= phase_next;
      count <= count_next;
      sum   <= sum_next;
    end
  end

  always_comb begin
    phase_next   = phase;
    count_next   = count;
    sum_next     = sum;
    push         = 1'b0;
    entry.data   = rx.rx_byte;
    entry.idx    = count;
    entry.commit = 1'b0;
    if (accept) begin
      unique case (phase)
        pcfp_pkg::PH_HUNT1: begin
          count_next = '0;
          sum_next   = '0;
          entry.idx  = '0;
          if (rx.rx_byte == first_preamble) begin
            push       = 1'b1;
            count_next = pcfp_pkg::INDEX_W'(1);
            sum_next   = rx.rx_byte;
            phase_next = pcfp_pkg::PH_HUNT2;
          end
        end
        pcfp_pkg::PH_HUNT2: begin
          if (rx.rx_byte == second_preamble) begin
            push       = 1'b1;
            count_next = count + 1'b1;
            sum_next   = sum + rx.rx_byte;
            phase_next = pcfp_pkg::PH_DATA;
          end else begin
            phase_next = pcfp_pkg::PH_HUNT1;
          end
        end
        pcfp_pkg::PH_DATA: begin
          push       = 1'b1;
          count_next = count + 1'b1;
          sum_next   = sum + rx.rx_byte;
          if (count_next >= pcfp_pkg::LAST_IDX) begin
            phase_next = pcfp_pkg::PH_SUM;
          end
        end
        pcfp_pkg::PH_SUM: begin
          count_next = count + 1'b1;
          if (sum == rx.rx_byte) begin
            push         = 1'b1;
            entry.commit = 1'b1;
          end
          phase_next = pcfp_pkg::PH_HUNT1;
        end
        default: phase_next = pcfp_pkg::PH_HUNT1;
      endcase
    end
  end

endmodule

// ----- design/pcfp_queue.sv -----
// Short request queue between the front end and the frame read-out.
module pcfp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pcfp_pkg::entry_t  push_entry,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output pcfp_pkg::entry_t  head
);

  pcfp_pkg::entry_t               slots [pcfp_pkg::QUEUE_DEPTH];
  logic [pcfp_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [pcfp_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [pcfp_pkg::QUEUE_AW:0]    used;
  logic                           do_push;
  logic                           do_pop;

  assign full      = used == (pcfp_pkg::QUEUE_AW + 1)'(pcfp_pkg::QUEUE_DEPTH);
  assign not_empty = used != '0;
  assign head      = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        used <= used + 1'b1;
      end else if (do_pop && !do_push) begin
        used <= used - 1'b1;
      end
    end
  end

endmodule

// ----- design/pcfp_back.sv -----
// Back end: frame store and read-out of a checked frame.
module pcfp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  pcfp_pkg::entry_t  q_entry,
  output logic              pop,
  pcfp_frame_if.source      frame
);

  logic [pcfp_pkg::BYTE_W-1:0]   store [pcfp_pkg::FRAME_LEN];
  logic [pcfp_pkg::BYTE_W-1:0]   rd_data;
  logic [pcfp_pkg::FRAME_AW-1:0] rd_cnt;
  logic [pcfp_pkg::INDEX_W-1:0]  out_index;
  logic                          out_last;
  logic                          out_valid;
  logic                          busy;
  logic                          issue;
  logic                          rd_final;

  assign pop      = q_valid && !busy;
  assign issue    = busy && (!out_valid || frame.ready);
  assign rd_final = rd_cnt == pcfp_pkg::FRAME_AW'(pcfp_pkg::FRAME_LEN - 1);

  assign frame.valid      = out_valid;
  assign frame.frame_byte = rd_data;
  assign frame.byte_index = out_index;
  assign frame.frame_last = out_last;

  always_ff @(posedge clk) begin
    if (pop) begin
      store[q_entry.idx[pcfp_pkg::FRAME_AW-1:0]] <= q_entry.data;
    end
    if (issue) begin
      rd_data   <= store[rd_cnt];
      out_index <= pcfp_pkg::INDEX_W'(rd_cnt);
      out_last  <= rd_final;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      rd_cnt    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop && q_entry.commit) begin
        busy   <= 1'b1;
        rd_cnt <= '0;
      end else if (issue) begin
        rd_cnt <= rd_cnt + 1'b1;
        if (rd_final) begin
          busy <= 1'b0;
        end
      end
      if (issue) begin
        out_valid <= 1'b1;
      end else if (frame.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- dv/tb_preamble_checksum_frame_parser_top.sv -----
// Self-checking testbench of the preamble checksum frame parser top level.
module tb_preamble_checksum_frame_parser_top;

  typedef struct packed {
    logic [pcfp_pkg::BYTE_W-1:0]  data;
    logic [pcfp_pkg::INDEX_W-1:0] idx;
    logic                         last;
  } frame_beat_t;

  typedef struct packed {
    logic [pcfp_pkg::BYTE_W-1:0] rx;
    logic                        typed;
    logic [6:0]                  n_out;
  } probe_row_t;

  localparam logic [pcfp_pkg::CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [pcfp_pkg::CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int unsigned DIRECTED_ROWS = 36;
  localparam int unsigned PHASE_QUOTA   = 78;
  localparam int unsigned IDLE_CYCLES   = 2 * pcfp_pkg::FRAME_LEN + pcfp_pkg::QUEUE_DEPTH + 8;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned HOLD_AFTER    = pcfp_pkg::FRAME_LEN + 4;
  localparam int unsigned STALL_LIMIT   = 4000;

  localparam probe_row_t PROBE_ROWS [DIRECTED_ROWS] = '{
    '{8'h00, 1'b1, 7'd0},  '{8'hAA, 1'b0, 7'd0},  '{8'hAA, 1'b1, 7'd0},  '{8'h55, 1'b1, 7'd0},
    '{8'hAA, 1'b0, 7'd0},  '{8'h55, 1'b0, 7'd0},  '{8'hFF, 1'b0, 7'd0},  '{8'h00, 1'b0, 7'd0},
    '{8'h01, 1'b0, 7'd0},  '{8'h80, 1'b0, 7'd0},  '{8'h7F, 1'b0, 7'd0},  '{8'h00, 1'b0, 7'd0},
    '{8'h00, 1'b0, 7'd0},  '{8'h00, 1'b0, 7'd0},  '{8'h00, 1'b0, 7'd0},  '{8'h00, 1'b0, 7'd0},
    '{8'h00, 1'b0, 7'd0},  '{8'h00, 1'b0, 7'd0},  '{8'h00, 1'b0, 7'd0},  '{8'hFE, 1'b1, 7'd16},
    '{8'hAA, 1'b0, 7'd0},  '{8'h55, 1'b0, 7'd0},  '{8'h00, 1'b0, 7'd0},  '{8'h00, 1'b0, 7'd0},
    '{8'h00, 1'b0, 7'd0},  '{8'h00, 1'b0, 7'd0},  '{8'h00, 1'b0, 7'd0},  '{8'h00, 1'b0, 7'd0},
    '{8'h00, 1'b0, 7'd0},  '{8'h00, 1'b0, 7'd0},  '{8'h00, 1'b0, 7'd0},  '{8'h00, 1'b0, 7'd0},
    '{8'h00, 1'b0, 7'd0},  '{8'h00, 1'b0, 7'd0},  '{8'h00, 1'b0, 7'd0},  '{8'h00, 1'b1, 7'd0}
  };

  logic clk = 1'b0;
  logic rst;

  pcfp_rx_if    rx_ch ();
  pcfp_cfg_if   cfg_ch ();
  pcfp_frame_if frame_ch ();

  preamble_checksum_frame_parser_top i_dut (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx_ch),
    .cfg   (cfg_ch),
    .frame (frame_ch)
  );

  always #4 clk = ~clk;

  logic [pcfp_pkg::BYTE_W-1:0]  pre_first;
  logic [pcfp_pkg::BYTE_W-1:0]  pre_second;
  pcfp_pkg::phase_t             parse_st;
  logic [pcfp_pkg::INDEX_W-1:0] stored_cnt;
  logic [pcfp_pkg::BYTE_W-1:0]  byte_sum;
  logic [pcfp_pkg::BYTE_W-1:0]  frame_buf [pcfp_pkg::FRAME_LEN];
  frame_beat_t                  expected_beats [$];

  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned beats_checked;
  int unsigned frames_passed;
  int unsigned frames_dropped;
  int unsigned cfg_writes;
  int unsigned settings_used;
  int unsigned traffic_left;
  int unsigned tx_calm;
  int unsigned rx_calm;
  bit          held_off;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("tb: mismatch %0d at %0t: %s", mismatches, $time, msg);
  endtask

  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 40);
    return $urandom_range(0, 8);
  endfunction

  function automatic void keep_frame_byte(input logic [pcfp_pkg::BYTE_W-1:0] b);
    if (stored_cnt < pcfp_pkg::FRAME_LEN) frame_buf[stored_cnt[pcfp_pkg::FRAME_AW-1:0]] = b;
    stored_cnt = stored_cnt + 6'd1;
  endfunction

  task automatic parse_rx_byte(input logic [pcfp_pkg::BYTE_W-1:0] b, output int unsigned made);
    made = 0;
    case (parse_st)
      pcfp_pkg::PH_HUNT2: begin
        if (b == pre_second) begin
          keep_frame_byte(b);
          byte_sum = byte_sum + b;
          parse_st = pcfp_pkg::PH_DATA;
        end else begin
          parse_st = pcfp_pkg::PH_HUNT1;
        end
      end
      pcfp_pkg::PH_DATA: begin
        keep_frame_byte(b);
        byte_sum = byte_sum + b;
        if (stored_cnt >= pcfp_pkg::FRAME_LEN - 1) parse_st = pcfp_pkg::PH_SUM;
      end
      pcfp_pkg::PH_SUM: begin
        keep_frame_byte(b);
        if (byte_sum == b) begin
          for (int i = 0; i < pcfp_pkg::FRAME_LEN; i++)
            expected_beats.push_back(frame_beat_t'{frame_buf[i], pcfp_pkg::INDEX_W'(i),
                                                   1'(i == pcfp_pkg::FRAME_LEN - 1)});
          made = pcfp_pkg::FRAME_LEN;
          frames_passed++;
        end else begin
          frames_dropped++;
        end
        parse_st = pcfp_pkg::PH_HUNT1;
      end
      default: begin
        stored_cnt = '0;
        byte_sum = '0;
        if (b == pre_first) begin
          keep_frame_byte(b);
          byte_sum = b;
          parse_st = pcfp_pkg::PH_HUNT2;
        end
      end
    endcase
  endtask

  task automatic offer_rx_byte(input logic [pcfp_pkg::BYTE_W-1:0] b, output int unsigned made);
    int unsigned gap;
    gap = draw_wait(tx_calm);
    if (gap != 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    bytes_sent++;
    parse_rx_byte(b, made);
  endtask

  task automatic write_preamble_reg(input logic [pcfp_pkg::CFG_INDEX_W-1:0] idx,
                                    input logic [pcfp_pkg::BYTE_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_writes++;
    if (idx == pcfp_pkg::REG_FIRST_PREAMBLE) pre_first = value;
    else if (idx == pcfp_pkg::REG_SECOND_PREAMBLE) pre_second = value;
  endtask

  task automatic wait_block_idle();
    rx_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_frame(input bit sum_ok);
    logic [pcfp_pkg::BYTE_W-1:0] body [pcfp_pkg::FRAME_LEN];
    logic [pcfp_pkg::BYTE_W-1:0] sum;
    int unsigned made;
    body[0] = pre_first;
    body[1] = pre_second;
    sum = body[0] + body[1];
    for (int i = 2; i < pcfp_pkg::FRAME_LEN - 1; i++) begin
      body[i] = pcfp_pkg::BYTE_W'($urandom_range(0, 255));
      sum = sum + body[i];
    end
    body[pcfp_pkg::FRAME_LEN-1] = sum_ok ? sum : sum + pcfp_pkg::BYTE_W'($urandom_range(1, 255));
    for (int i = 0; i < pcfp_pkg::FRAME_LEN; i++) offer_rx_byte(body[i], made);
    traffic_left = (traffic_left > pcfp_pkg::FRAME_LEN) ?
                   traffic_left - pcfp_pkg::FRAME_LEN : 0;
  endtask

  task automatic send_broken_header();
    logic [pcfp_pkg::BYTE_W-1:0] wrong;
    int unsigned made;
    wrong = pcfp_pkg::BYTE_W'($urandom_range(0, 255));
    while (wrong == pre_second) wrong = pcfp_pkg::BYTE_W'($urandom_range(0, 255));
    offer_rx_byte(pre_first, made);
    offer_rx_byte(wrong, made);
    traffic_left = (traffic_left > 2) ? traffic_left - 2 : 0;
  endtask

  task automatic send_noise();
    int unsigned made;
    repeat ($urandom_range(1, 4)) offer_rx_byte(pcfp_pkg::BYTE_W'($urandom_range(0, 255)), made);
  endtask

  task automatic run_random_traffic(input int unsigned quota);
    int unsigned pick;
    settings_used++;
    traffic_left = quota;
    while (traffic_left != 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) send_frame(1'b1);
      else if (pick < 75) send_frame(1'b0);
      else if (pick < 87) send_broken_header();
      else send_noise();
    end
  endtask

  task automatic check_frame_beat();
    frame_beat_t want;
    beats_checked++;
    if (expected_beats.size() == 0) begin
      report_mismatch($sformatf("unexpected byte %02h index %0d last %0b",
                                frame_ch.frame_byte, frame_ch.byte_index, frame_ch.frame_last));
      return;
    end
    want = expected_beats.pop_front();
    if (frame_ch.frame_byte !== want.data || frame_ch.byte_index !== want.idx ||
        frame_ch.frame_last !== want.last)
      report_mismatch($sformatf("got byte %02h index %0d last %0b, want %02h %0d %0b",
                                frame_ch.frame_byte, frame_ch.byte_index, frame_ch.frame_last,
                                want.data, want.idx, want.last));
  endtask

  initial begin : frame_receiver
    int unsigned gap;
    frame_ch.ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = draw_wait(rx_calm);
      // A long stall in the middle of a frame drain backs up the request queue.
      if (!held_off && beats_checked >= HOLD_AFTER &&
          (beats_checked % pcfp_pkg::FRAME_LEN) != 0 && traffic_left >= 40) begin
        gap = HOLD_CYCLES;
        held_off = 1'b1;
      end
      if (gap != 0) begin
        frame_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      frame_ch.ready <= 1'b1;
      @(posedge clk);
      while (!frame_ch.valid) @(posedge clk);
      check_frame_beat();
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((rx_ch.valid && rx_ch.ready) || (frame_ch.valid && frame_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int unsigned made;
    logic [pcfp_pkg::BYTE_W-1:0] same;
    rst = 1'b1;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    pre_first = 8'hAA;
    pre_second = 8'h55;
    parse_st = pcfp_pkg::PH_HUNT1;
    stored_cnt = '0;
    byte_sum = '0;
    foreach (frame_buf[i]) frame_buf[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      offer_rx_byte(PROBE_ROWS[r].rx, made);
      if (PROBE_ROWS[r].typed && made != PROBE_ROWS[r].n_out)
        report_mismatch($sformatf("directed row %0d caused %0d frame bytes, want %0d",
                                  r, made, PROBE_ROWS[r].n_out));
    end
    run_random_traffic(PHASE_QUOTA);

    wait_block_idle();
    write_preamble_reg(pcfp_pkg::REG_FIRST_PREAMBLE, 8'h00);
    write_preamble_reg(pcfp_pkg::REG_SECOND_PREAMBLE, 8'hFF);
    write_preamble_reg(REG_SPARE_2, pcfp_pkg::BYTE_W'($urandom_range(0, 255)));
    cfg_ch.valid <= 1'b0;
    run_random_traffic(PHASE_QUOTA);

    wait_block_idle();
    write_preamble_reg(pcfp_pkg::REG_SECOND_PREAMBLE, 8'h00);
    write_preamble_reg(pcfp_pkg::REG_FIRST_PREAMBLE, 8'hFF);
    write_preamble_reg(REG_SPARE_3, pcfp_pkg::BYTE_W'($urandom_range(0, 255)));
    cfg_ch.valid <= 1'b0;
    run_random_traffic(PHASE_QUOTA);

    // Both preambles equal, so a repeated first byte is never taken as a new start.
    wait_block_idle();
    same = pcfp_pkg::BYTE_W'($urandom_range(0, 255));
    write_preamble_reg(pcfp_pkg::REG_FIRST_PREAMBLE, same);
    write_preamble_reg(pcfp_pkg::REG_SECOND_PREAMBLE, same);
    cfg_ch.valid <= 1'b0;
    run_random_traffic(PHASE_QUOTA);

    wait_block_idle();
    write_preamble_reg(pcfp_pkg::REG_SECOND_PREAMBLE, pcfp_pkg::BYTE_W'($urandom_range(0, 255)));
    write_preamble_reg(pcfp_pkg::REG_FIRST_PREAMBLE, pcfp_pkg::BYTE_W'($urandom_range(0, 255)));
    cfg_ch.valid <= 1'b0;
    run_random_traffic(PHASE_QUOTA);

    wait_block_idle();
    if (expected_beats.size() != 0)
      report_mismatch($sformatf("%0d frame bytes never arrived", expected_beats.size()));
    $display("tb: %0d byte requests sent, %0d frames passed the checksum, %0d dropped",
             bytes_sent, frames_passed, frames_dropped);
    $display("tb: %0d register writes over %0d preamble settings, %0d frame bytes checked%s",
             cfg_writes, settings_used, beats_checked,
             held_off ? ", output held off once" : "");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/pcfp_pkg.sv
design/pcfp_if.sv
design/pcfp_front.sv
design/pcfp_queue.sv
design/pcfp_back.sv
design/preamble_checksum_frame_parser_top.sv
dv/tb_preamble_checksum_frame_parser_top.sv
